@@ rtl/core/stks_pkg.sv @@
// shared types and constants of the streaming top-k select block
`default_nettype none
package stks_pkg;

	localparam int KEEP_W = 5;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd10;

	typedef struct packed {
		logic wr;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/stks_if.sv @@
// score and kept-entry channel interfaces of the streaming top-k select block
`default_nettype none
interface stks_score_if #(
	parameter int SCORE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [SCORE_WIDTH-1:0] score;
	logic                   end_of_row;

	modport source (output valid, output score, output end_of_row, input ready);
	modport sink (input valid, input score, input end_of_row, output ready);
endinterface

interface stks_kept_if #(
	parameter int SCORE_WIDTH    = 32,
	parameter int POSITION_WIDTH = 16
);
	logic                      valid;
	logic                      ready;
	logic [SCORE_WIDTH-1:0]    kept_score;
	logic [POSITION_WIDTH-1:0] element_index;
	logic                      last_of_list;

	modport source (output valid, output kept_score, output element_index,
		output last_of_list, input ready);
	modport sink (input valid, input kept_score, input element_index,
		input last_of_list, output ready);
endinterface
`default_nettype wire

@@ rtl/core/stks_cell.sv @@
// one slot of the kept-score chain with its stage of the minimum search
`default_nettype none
module stks_cell #(
	parameter int SCORE_WIDTH    = 32,
	parameter int POSITION_WIDTH = 16,
	parameter int IDX_W          = 4,
	parameter int CELL_INDEX     = 0
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire stks_pkg::cell_ctl_t ctl,
	input  wire                      used,
	input  wire [SCORE_WIDTH-1:0]    wr_score,
	input  wire [POSITION_WIDTH-1:0] wr_pos,
	input  wire [SCORE_WIDTH-1:0]    nxt_score,
	input  wire [POSITION_WIDTH-1:0] nxt_pos,
	input  wire                      min_in_act,
	input  wire [SCORE_WIDTH-1:0]    min_in_score,
	input  wire [IDX_W-1:0]          min_in_idx,
	output logic                     min_out_act,
	output logic [SCORE_WIDTH-1:0]   min_out_score,
	output logic [IDX_W-1:0]         min_out_idx,
	output logic [SCORE_WIDTH-1:0]   score,
	output logic [POSITION_WIDTH-1:0] pos
);

	logic [SCORE_WIDTH-1:0]    score_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic                      act_q;
	logic [SCORE_WIDTH-1:0]    min_score_q;
	logic [IDX_W-1:0]          min_idx_q;
	logic                      take_own;

	// slot contents
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			score_q <= wr_score;
			pos_q   <= wr_pos;
		end else if (ctl.shift) begin
			score_q <= nxt_score;
			pos_q   <= nxt_pos;
		end
	end

	// running minimum, strictly less keeps the earlier slot on ties
	assign take_own = used && (score_q < min_in_score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= min_in_act;
		end
	end

	always_ff @(posedge clk) begin
		if (take_own) begin
			min_score_q <= score_q;
			min_idx_q   <= IDX_W'(CELL_INDEX);
		end else begin
			min_score_q <= min_in_score;
			min_idx_q   <= min_in_idx;
		end
	end

	assign min_out_act   = act_q;
	assign min_out_score = min_score_q;
	assign min_out_idx   = min_idx_q;
	assign score         = score_q;
	assign pos           = pos_q;

endmodule
`default_nettype wire

@@ rtl/core/streaming_top_k_select.sv @@
// streaming top-k select: keeps the largest scores of each row and lists them at row end
//
// scores: one request per score, end_of_row on the last score of a row.
// kept: at row end one request per kept slot, in slot order, last_of_list on
//   the final one; a row always yields at least one entry.
// keep_count_we / keep_count: how many scores are kept, 0 acts as 1 and values
//   above MAX_KEEP act as MAX_KEEP; write only while the block is idle.
// a score that lands in a free slot is written as it is taken; once the slots are full
//   the minimum search token enters the cell chain the cycle after the request
//   and walks it one cell per cycle before the replacement is written.
// scores are not taken while a search or a row listing is in progress.
// listing: the first entry is offered the cycle after the row's last score
//   settles, then one entry per cycle while the receiver is ready; each taken
//   entry shifts the chain by one cell, so a stalled receiver holds the current entry.
// reset empties all slots, restarts the row position and sets keep_count to 10.
// positions count from 0 and saturate at the maximum of POSITION_WIDTH bits.
`default_nettype none
module streaming_top_k_select #(
	parameter int MAX_KEEP       = 16,
	parameter int POSITION_WIDTH = 16,
	parameter int SCORE_WIDTH    = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             keep_count_we,
	input  wire [stks_pkg::KEEP_W-1:0]      keep_count,
	stks_score_if.sink                      scores,
	stks_kept_if.source                     kept
);

	localparam int CNT_W = $clog2(MAX_KEEP + 1);
	localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int CMP_W = ((CNT_W > stks_pkg::KEEP_W) ? CNT_W : stks_pkg::KEEP_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t                      state_q;
	logic [stks_pkg::KEEP_W-1:0] keep_q;
	logic [CNT_W-1:0]            filled_q;
	logic [POSITION_WIDTH-1:0]   row_pos_q;
	logic                        start_q;
	logic [SCORE_WIDTH-1:0]      s_q;
	logic [POSITION_WIDTH-1:0]   p_q;
	logic                        eor_q;

	logic [CMP_W-1:0]            k_eff;
	logic                        acc;
	logic                        do_fill;
	logic                        replace;
	logic                        out_hs;
	logic [SCORE_WIDTH-1:0]      wd_score;
	logic [POSITION_WIDTH-1:0]   wd_pos;

	logic                        m_act   [0:MAX_KEEP];
	logic [SCORE_WIDTH-1:0]      m_score [0:MAX_KEEP];
	logic [IDX_W-1:0]            m_idx   [0:MAX_KEEP];
	logic [SCORE_WIDTH-1:0]      slot_score [0:MAX_KEEP-1];
	logic [POSITION_WIDTH-1:0]   slot_pos   [0:MAX_KEEP-1];
	stks_pkg::cell_ctl_t         ctl        [0:MAX_KEEP-1];

	always_comb begin
		if (keep_q == '0) begin
			k_eff = CMP_W'(1);
		end else if (CMP_W'(keep_q) > CMP_W'(MAX_KEEP)) begin
			k_eff = CMP_W'(MAX_KEEP);
		end else begin
			k_eff = CMP_W'(keep_q);
		end
	end

	assign scores.ready = (state_q == ST_IDLE);
	assign acc          = scores.valid && scores.ready;
	assign do_fill      = CMP_W'(filled_q) < k_eff;
	assign replace      = m_act[MAX_KEEP] && (s_q > m_score[MAX_KEEP]);
	assign out_hs       = kept.valid && kept.ready;
	assign wd_score     = (state_q == ST_SEARCH) ? s_q : scores.score;
	assign wd_pos       = (state_q == ST_SEARCH) ? p_q : row_pos_q;

	assign kept.valid         = (state_q == ST_EMIT);
	assign kept.kept_score    = slot_score[0];
	assign kept.element_index = slot_pos[0];
	assign kept.last_of_list  = (filled_q == CNT_W'(1));

	// search token enters with the largest score and index 0, so slot 0 is the first candidate
	assign m_act[0]   = start_q;
	assign m_score[0] = '1;
	assign m_idx[0]   = '0;

	genvar j;
	generate
		for (j = 0; j < MAX_KEEP; j++) begin : g_cell
			logic [SCORE_WIDTH-1:0]    nxt_score;
			logic [POSITION_WIDTH-1:0] nxt_pos;

			if (j == MAX_KEEP - 1) begin : g_tail
				assign nxt_score = slot_score[j];
				assign nxt_pos   = slot_pos[j];
			end else begin : g_body
				assign nxt_score = slot_score[j+1];
				assign nxt_pos   = slot_pos[j+1];
			end

			assign ctl[j].wr = (acc && do_fill && (filled_q == CNT_W'(j)))
				|| (replace && (m_idx[MAX_KEEP] == IDX_W'(j)));
			assign ctl[j].shift = out_hs;

			stks_cell #(
				.SCORE_WIDTH    (SCORE_WIDTH),
				.POSITION_WIDTH (POSITION_WIDTH),
				.IDX_W          (IDX_W),
				.CELL_INDEX     (j)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctl           (ctl[j]),
				.used          (CNT_W'(j) < filled_q),
				.wr_score      (wd_score),
				.wr_pos        (wd_pos),
				.nxt_score     (nxt_score),
				.nxt_pos       (nxt_pos),
				.min_in_act    (m_act[j]),
				.min_in_score  (m_score[j]),
				.min_in_idx    (m_idx[j]),
				.min_out_act   (m_act[j+1]),
				.min_out_score (m_score[j+1]),
				.min_out_idx   (m_idx[j+1]),
				.score         (slot_score[j]),
				.pos           (slot_pos[j])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= stks_pkg::KEEP_RESET;
		end else if (keep_count_we) begin
			keep_q <= keep_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			filled_q  <= '0;
			row_pos_q <= '0;
			start_q   <= 1'b0;
		end else begin
			start_q <= acc && !do_fill;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (row_pos_q != '1) begin
							row_pos_q <= row_pos_q + POSITION_WIDTH'(1);
						end
						if (do_fill) begin
							filled_q <= filled_q + CNT_W'(1);
							if (scores.end_of_row) begin
								state_q <= ST_EMIT;
							end
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (m_act[MAX_KEEP]) begin
						state_q <= eor_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_hs) begin
						filled_q <= filled_q - CNT_W'(1);
						if (filled_q == CNT_W'(1)) begin
							state_q   <= ST_IDLE;
							row_pos_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request held while the search runs
	always_ff @(posedge clk) begin
		if (acc) begin
			s_q   <= scores.score;
			p_q   <= row_pos_q;
			eor_q <= scores.end_of_row;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= CNT_W'(MAX_KEEP))
		else $error("slot count beyond chain length");

	a_token_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		m_act[MAX_KEEP] |-> (state_q == ST_SEARCH))
		else $error("search token outside a search");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		kept.valid |-> (filled_q != '0))
		else $error("listing with no filled slot");

	a_row_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_hs && kept.last_of_list) |=> ((filled_q == '0) && (row_pos_q == '0)))
		else $error("row state not cleared after listing");

	a_search_starts_full: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (filled_q != '0))
		else $error("search started on empty chain");

endmodule
`default_nettype wire
